[rtl/psgh_pkg.sv]
// Shared types, constants and elaboration-time table functions for the
// Platt sigmoid gradient/Hessian accumulator. No dependencies.
`timescale 1ns / 1ps
package psgh_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int EXP_ENTRIES_DEF = 256;

    localparam int EXP_CUTOFF = 32;
    localparam int LOG_ROUNDS = 24;
    localparam int DIV_STEPS  = 17;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    localparam logic [2:0] CFG_SLOPE         = 3'd0;
    localparam logic [2:0] CFG_INTERCEPT     = 3'd1;
    localparam logic [2:0] CFG_TARGET_LOW    = 3'd2;
    localparam logic [2:0] CFG_TARGET_HIGH   = 3'd3;
    localparam logic [2:0] CFG_HESSIAN_RIDGE = 3'd4;

    typedef struct packed {
        logic signed [31:0] decision_value;
        logic               label_positive;
        logic               last_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [47:0] objective;
        logic signed [47:0] grad_slope;
        logic signed [47:0] grad_intercept;
        logic signed [47:0] hess_slope_slope;
        logic signed [47:0] hess_slope_intercept;
        logic signed [47:0] hess_intercept_intercept;
    } t_out_beat;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_MUL_Z,
        OP_Z,
        OP_ABS,
        OP_MUL_Y,
        OP_POS,
        OP_IDX,
        OP_T0,
        OP_T1,
        OP_MUL_V,
        OP_V,
        OP_E,
        OP_DIV_INIT,
        OP_ITER,
        OP_MUL_LN,
        OP_LN,
        OP_CZH,
        OP_PQ,
        OP_GS,
        OP_DPQ,
        OP_HSI,
        OP_MUL_HSS,
        OP_HSS,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] round;
        logic       load;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

    function automatic logic [63:0] pow_q32(input logic [63:0] r, input int n);
        logic [63:0] res;
        logic [63:0] base;
        int          m;
        res  = 64'h1_0000_0000;
        base = r;
        m    = n;
        while (m != 0) begin
            if (m % 2 == 1) res = (res * base) >> 32;
            base = (base * base) >> 32;
            m    = m / 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] exp_ratio(input int entries);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'h8000_0000;
        hi = 64'hFFFF_FFFF;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow_q32(mid, entries) <= 64'h8000_0000) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [32:0] exp_rom_entry(input int idx, input int entries,
                                                  input logic [63:0] ratio);
        logic [63:0] v;
        int          i;
        v = 64'h1_0000_0000;
        if (idx >= entries) begin
            v = 64'h8000_0000;
        end else begin
            for (i = 1; i <= idx; i++) v = (v * ratio + 64'h8000_0000) >> 32;
        end
        return v[32:0];
    endfunction

endpackage

[rtl/platt_sigmoid_grad_hessian_core.sv]
// Each sample steps through the sequencer states on the shared multiplier, including
// the 24-round log squaring loop; the input is stalled until the sample is done.
// A last sample that finds the previous result beat still waiting holds in its
// final state, with the input stalled, until that beat is taken.
// Reset (synchronous, active low) clears sums and output valid and loads
// config defaults: slope 0, intercept 0, targets 0 / 65535, ridge 1.
`timescale 1ns / 1ps
module platt_sigmoid_grad_hessian_core #(
    parameter int FRACTION_BITS     = psgh_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = psgh_pkg::EXP_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  psgh_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output psgh_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata
);
    import psgh_pkg::*;

    t_cmd    cmd;
    t_status status;

    psgh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    psgh_datapath #(
        .FRACTION_BITS     (FRACTION_BITS),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accepted beat");

    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat raised while idle");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_in_stall) |=> !o_out_valid)
        else $error("result beat appeared without a sample in flight");

endmodule

[rtl/psgh_ctrl.sv]
// Sequencer for the Platt accumulator: steps one sample through the shared
// datapath. Depends on psgh_pkg.
`timescale 1ns / 1ps
module psgh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  psgh_pkg::t_status i_status,
    output psgh_pkg::t_cmd    o_cmd
);
    import psgh_pkg::*;

    t_op        r_state, n_state;
    logic [4:0] r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        o_cmd       = '0;
        o_cmd.op    = r_state;
        o_cmd.round = r_round;
        unique case (r_state)
            OP_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = OP_MUL_Z;
                end
            end
            OP_MUL_Z:    n_state = OP_Z;
            OP_Z:        n_state = OP_ABS;
            OP_ABS:      n_state = OP_MUL_Y;
            OP_MUL_Y:    n_state = OP_POS;
            OP_POS:      n_state = OP_IDX;
            OP_IDX:      n_state = OP_T0;
            OP_T0:       n_state = OP_T1;
            OP_T1:       n_state = OP_MUL_V;
            OP_MUL_V:    n_state = OP_V;
            OP_V:        n_state = OP_E;
            OP_E:        n_state = OP_DIV_INIT;
            OP_DIV_INIT: begin
                n_state = OP_ITER;
                n_round = '0;
            end
            OP_ITER: begin
                if (r_round == 5'(LOG_ROUNDS - 1)) begin
                    n_state = OP_MUL_LN;
                end else begin
                    n_round = r_round + 5'd1;
                end
            end
            OP_MUL_LN:   n_state = OP_LN;
            OP_LN:       n_state = OP_CZH;
            OP_CZH:      n_state = OP_PQ;
            OP_PQ:       n_state = OP_GS;
            OP_GS:       n_state = OP_DPQ;
            OP_DPQ:      n_state = OP_HSI;
            OP_HSI:      n_state = OP_MUL_HSS;
            OP_MUL_HSS:  n_state = OP_HSS;
            OP_HSS:      n_state = OP_EMIT;
            OP_EMIT: begin
                if (!i_status.last) begin
                    n_state = OP_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = OP_IDLE;
                end
            end
            default:     n_state = OP_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != OP_IDLE);

endmodule

[rtl/psgh_datapath.sv]
// Datapath: config registers, shared 34x34 multiplier, exp table, divider,
// log squaring loop, saturating sums and output register. Depends on psgh_pkg.
`timescale 1ns / 1ps
module psgh_datapath #(
    parameter int FRACTION_BITS     = psgh_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = psgh_pkg::EXP_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psgh_pkg::t_cmd      i_cmd,
    output psgh_pkg::t_status   o_status,
    input  psgh_pkg::t_in_beat  i_in_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output psgh_pkg::t_out_beat o_out_data
);
    import psgh_pkg::*;

    localparam int          IDX_W     = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam logic [63:0] EXP_RATIO = exp_ratio(EXP_TABLE_ENTRIES);
    localparam logic [47:0] EXP_LIMIT = 48'(EXP_CUTOFF) << FRACTION_BITS;
    localparam logic signed [68:0] Z_MAX  = 69'sh7FFF_FFFF_FFFF;
    localparam logic signed [68:0] SAT_HI = 69'sh7FFF_FFFF_FFFF;
    localparam logic signed [68:0] SAT_LO = -SAT_HI - 69'sd1;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                   input logic signed [67:0] term);
        logic signed [68:0] s;
        s = 69'(acc) + 69'(term);
        if (s > SAT_HI) return SAT_HI[47:0];
        if (s < SAT_LO) return SAT_LO[47:0];
        return s[47:0];
    endfunction

    // 2^(-x) table for x = idx / entries over [0, 1], Q1.32
    logic [32:0] rom [0:EXP_TABLE_ENTRIES];
    for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [32:0] ROM_WORD = exp_rom_entry(gi, EXP_TABLE_ENTRIES, EXP_RATIO);
        assign rom[gi] = ROM_WORD;
    end

    logic signed [31:0] r_slope, r_intercept;
    logic [15:0]        r_target_low, r_target_high, r_ridge;

    logic signed [31:0] r_d;
    logic [15:0]        r_t;
    logic               r_last;
    logic signed [47:0] r_z;
    logic [32:0]        r_a;
    logic               r_cut;
    logic [5:0]         r_k;
    logic [IDX_W-1:0]   r_idx;
    logic [FRACTION_BITS-1:0] r_rem;
    logic [32:0]        r_t0, r_diff, r_v;
    logic [16:0]        r_e;
    logic [17:0]        r_den, r_part;
    logic [16:0]        r_dvd, r_quo;
    logic [31:0]        r_x;
    logic [23:0]        r_res;
    logic               r_log_two;
    logic [16:0]        r_p, r_q;
    logic [24:0]        r_ln;
    logic signed [65:0] r_cz;
    logic [30:0]        r_pq;
    logic signed [33:0] r_dpq;
    logic signed [67:0] r_prod;

    logic signed [47:0] r_loss, r_gs, r_gi, r_hss, r_hsi, r_hii;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [17:0] c_sel, diff_tp;
    logic [IDX_W-1:0]   rom_addr;
    logic [32:0]        rom_rd;
    logic signed [68:0] z_wide, z_clamp;
    logic [47:0]        z_abs;
    logic [32:0]        e_shift;
    logic [33:0]        e_sum;
    logic [32:0]        div_den_half;
    logic [17:0]        den_init;
    logic [32:0]        dividend;
    logic [18:0]        div_rem;
    logic               div_ge;
    logic [32:0]        log_sq;
    logic [57:0]        ln_sum;
    logic [24:0]        res_fin;
    logic signed [67:0] loss_term, gi_term, hii_term, ridge_term;
    logic               out_free;

    assign c_sel   = r_z[47] ? $signed({2'b0, r_t}) - 18'sd65536 : $signed({2'b0, r_t});
    assign diff_tp = $signed({2'b0, r_t}) - $signed({1'b0, r_p});
    assign res_fin = r_log_two ? 25'h100_0000 : {1'b0, r_res};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_Z: begin
                mul_a = 34'(r_slope);
                mul_b = 34'(r_d);
            end
            OP_MUL_Y: begin
                mul_a = $signed({1'b0, r_a});
                mul_b = $signed(34'(LOG2E_Q30));
            end
            OP_POS: begin
                mul_a = $signed(34'(r_prod[30 +: FRACTION_BITS]));
                mul_b = 34'(EXP_TABLE_ENTRIES);
            end
            OP_MUL_V: begin
                mul_a = $signed({1'b0, r_diff});
                mul_b = $signed(34'(r_rem));
            end
            OP_ITER: begin
                mul_a = $signed(34'(r_x));
                mul_b = $signed(34'(r_x));
            end
            OP_MUL_LN: begin
                mul_a = $signed(34'(res_fin));
                mul_b = $signed(34'(LN2_Q32));
            end
            OP_LN: begin
                mul_a = 34'(c_sel);
                mul_b = $signed(34'(r_z[23:0]));
            end
            OP_CZH: begin
                mul_a = 34'(c_sel);
                mul_b = 34'($signed(r_z[47:24]));
            end
            OP_PQ: begin
                mul_a = $signed(34'(r_p));
                mul_b = $signed(34'(r_q));
            end
            OP_GS: begin
                mul_a = 34'(r_d);
                mul_b = 34'(diff_tp);
            end
            OP_DPQ: begin
                mul_a = 34'(r_d);
                mul_b = $signed(34'(r_pq));
            end
            OP_MUL_HSS: begin
                mul_a = 34'(r_d);
                mul_b = r_dpq;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rom_addr = (i_cmd.op == OP_T1) ? r_idx + IDX_W'(1) : r_idx;
    assign rom_rd   = rom[rom_addr];

    always_comb begin
        z_wide = 69'(r_prod >>> FRACTION_BITS) + 69'(r_intercept);
        if (z_wide > Z_MAX)       z_clamp = Z_MAX;
        else if (z_wide < -Z_MAX) z_clamp = -Z_MAX;
        else                      z_clamp = z_wide;
    end

    assign z_abs   = r_z[47] ? 48'(-r_z) : 48'(r_z);
    assign e_shift = (r_k > 6'd32) ? 33'd0 : (r_v >> r_k);
    assign e_sum   = {1'b0, e_shift} + 34'd32768;

    assign den_init     = 18'(r_e) + 18'd65536;
    assign div_den_half = 33'(den_init >> 1);
    assign dividend     = 33'h1_0000_0000 + div_den_half;
    assign div_rem      = {r_part, r_dvd[16]};
    assign div_ge       = (div_rem >= {1'b0, r_den});
    assign log_sq       = mul_p[62:30];
    assign ln_sum       = 58'(r_prod) + 58'h8000_0000;

    assign loss_term  = 68'(r_cz >>> 16) + $signed({43'b0, r_ln});
    assign gi_term    = (68'(diff_tp) <<< FRACTION_BITS) >>> 16;
    assign hii_term   = $signed(68'(r_pq >> (32 - FRACTION_BITS)));
    assign ridge_term = $signed({52'b0, r_ridge});
    assign out_free   = !r_out_valid || !i_out_stall;

    // control state: config, sums, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope       <= '0;
            r_intercept   <= '0;
            r_target_low  <= '0;
            r_target_high <= 16'hFFFF;
            r_ridge       <= 16'd1;
            r_loss        <= '0;
            r_gs          <= '0;
            r_gi          <= '0;
            r_hss         <= '0;
            r_hsi         <= '0;
            r_hii         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLOPE:         r_slope       <= i_cfg_wdata;
                    CFG_INTERCEPT:     r_intercept   <= i_cfg_wdata;
                    CFG_TARGET_LOW:    r_target_low  <= i_cfg_wdata[15:0];
                    CFG_TARGET_HIGH:   r_target_high <= i_cfg_wdata[15:0];
                    CFG_HESSIAN_RIDGE: r_ridge       <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_GS) r_loss <= sat_add(r_loss, loss_term);
            if (i_cmd.op == OP_DPQ) begin
                r_gs <= sat_add(r_gs, r_prod >>> 16);
                r_gi <= sat_add(r_gi, gi_term);
            end
            if (i_cmd.op == OP_HSI) begin
                r_hsi <= sat_add(r_hsi, r_prod >>> 32);
                r_hii <= sat_add(r_hii, hii_term);
            end
            if (i_cmd.op == OP_HSS) r_hss <= sat_add(r_hss, r_prod >>> FRACTION_BITS);
            if (i_cmd.emit) begin
                r_loss      <= '0;
                r_gs        <= '0;
                r_gi        <= '0;
                r_hss       <= '0;
                r_hsi       <= '0;
                r_hii       <= '0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.load) begin
            r_d    <= i_in_data.decision_value;
            r_t    <= i_in_data.label_positive ? r_target_high : r_target_low;
            r_last <= i_in_data.last_sample;
        end
        if (i_cmd.emit) begin
            r_out.objective                <= r_loss;
            r_out.grad_slope               <= r_gs;
            r_out.grad_intercept           <= r_gi;
            r_out.hess_slope_slope         <= sat_add(r_hss, ridge_term);
            r_out.hess_slope_intercept     <= r_hsi;
            r_out.hess_intercept_intercept <= sat_add(r_hii, ridge_term);
        end
        unique case (i_cmd.op)
            OP_Z:   r_z <= z_clamp[47:0];
            OP_ABS: begin
                r_a   <= z_abs[32:0];
                r_cut <= (z_abs >= EXP_LIMIT);
            end
            OP_POS: r_k <= r_prod[(30 + FRACTION_BITS) +: 6];
            OP_IDX: begin
                r_idx <= r_prod[FRACTION_BITS +: IDX_W];
                r_rem <= r_prod[FRACTION_BITS-1:0];
            end
            OP_T0:  r_t0 <= rom_rd;
            OP_T1:  r_diff <= (r_t0 > rom_rd) ? r_t0 - rom_rd : 33'd0;
            OP_V:   r_v <= r_t0 - r_prod[FRACTION_BITS +: 33];
            OP_E:   r_e <= r_cut ? 17'd0 : e_sum[32:16];
            OP_DIV_INIT: begin
                r_den     <= den_init;
                r_part    <= 18'(dividend[32:17]);
                r_dvd     <= dividend[16:0];
                r_quo     <= '0;
                r_x       <= 32'(den_init) << 14;
                r_log_two <= r_e[16];
                r_res     <= '0;
            end
            OP_ITER: begin
                if (log_sq[32] || log_sq[31]) begin
                    r_x   <= log_sq[32:1];
                    r_res <= r_res | (24'd1 << (5'(LOG_ROUNDS - 1) - i_cmd.round));
                end else begin
                    r_x <= log_sq[31:0];
                end
                if (i_cmd.round < 5'(DIV_STEPS)) begin
                    r_part <= div_ge ? 18'(div_rem - {1'b0, r_den}) : div_rem[17:0];
                    r_dvd  <= r_dvd << 1;
                    r_quo  <= {r_quo[15:0], div_ge};
                end
            end
            OP_MUL_LN: begin
                if (r_z[47]) begin
                    r_p <= r_quo;
                    r_q <= 17'd65536 - r_quo;
                end else begin
                    r_p <= 17'd65536 - r_quo;
                    r_q <= r_quo;
                end
            end
            OP_LN:  r_ln <= ln_sum[56:32] >> (LOG_ROUNDS - FRACTION_BITS);
            OP_CZH: r_cz <= 66'(r_prod);
            OP_PQ:  r_cz <= r_cz + 66'(r_prod <<< 24);
            OP_GS:  r_pq <= r_prod[30:0];
            OP_HSI: r_dpq <= 34'(r_prod >>> 32);
            default: ;
        endcase
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
